[rtl/s5p_pkg.sv]
// s5p_pkg: shared types, protocol constants and status codes of the SOCKS5 request parser.
// Depends on nothing; every other file in rtl/ imports it.
package s5p_pkg;

   localparam logic [7:0] SOCKS_VERSION = 8'd5;
   localparam logic [7:0] CMD_CONNECT   = 8'd1;
   localparam logic [7:0] ATYP_IPV4     = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
   localparam logic [7:0] ATYP_IPV6     = 8'd4;

   // Message lengths and length offsets for the greeting and the connect request
   localparam logic [8:0] LEN_IPV4      = 9'd10;
   localparam logic [8:0] LEN_UNKNOWN   = 9'd6;
   localparam logic [8:0] LEN_DOMAIN0   = 9'd0;
   localparam logic [8:0] GREET_EXTRA   = 9'd2;
   localparam logic [8:0] DOMAIN_EXTRA  = 9'd7;

   // Byte positions within a message
   localparam logic [8:0] POS_VER       = 9'd0;
   localparam logic [8:0] POS_CMD       = 9'd1;
   localparam logic [8:0] POS_RSV       = 9'd2;
   localparam logic [8:0] POS_ATYP      = 9'd3;
   localparam logic [8:0] POS_ADDR0     = 9'd4;
   localparam logic [8:0] POS_ADDR3     = 9'd7;
   localparam logic [8:0] POS_NAME0     = 9'd5;

   typedef enum logic [2:0] {
      ST_PENDING     = 3'd0,
      ST_COMPLETE    = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_BAD_COMMAND = 3'd3,
      ST_IPV6        = 3'd4
   } status_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [8:0]  byte_count;
      logic [8:0]  expected_length;
      logic [7:0]  atyp_seen;
      logic [31:0] addr_accum;
      logic [15:0] port_accum;
   } state_type;

   typedef struct packed {
      status_type  status;
      logic [8:0]  msg_length;
      logic [7:0]  addr_type;
      logic [31:0] ipv4_addr;
      logic [15:0] dest_port;
      logic [7:0]  name_char;
      logic        name_char_valid;
   } result_type;

endpackage

[rtl/s5p_req_if.sv]
// s5p_req_if: valid/ready channel carrying one request (selector and raw byte).
// Depends on s5p_pkg.
interface s5p_req_if;
   import s5p_pkg::*;

   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

[rtl/s5p_rsp_if.sv]
// s5p_rsp_if: valid/ready channel carrying one parse result per request.
// Depends on s5p_pkg for the status type.
interface s5p_rsp_if;
   import s5p_pkg::*;

   logic        valid;
   logic        ready;
   status_type  status;
   logic [8:0]  msg_length;
   logic [7:0]  addr_type;
   logic [31:0] ipv4_addr;
   logic [15:0] dest_port;
   logic [7:0]  name_char;
   logic        name_char_valid;

   modport source (output valid, output status, output msg_length, output addr_type,
                   output ipv4_addr, output dest_port, output name_char,
                   output name_char_valid, input ready);
   modport sink   (input valid, input status, input msg_length, input addr_type,
                   input ipv4_addr, input dest_port, input name_char,
                   input name_char_valid, output ready);
endinterface

[rtl/socks5_request_parser.sv]
// socks5_request_parser: top level; request input register, parse step, result register.
// Depends on s5p_pkg, s5p_req_if, s5p_rsp_if and s5p_step.
//
//   channel  | dir | payload                                         | handshake
//   ---------+-----+-------------------------------------------------+-----------
//   req_bus  | in  | req_type, data_byte                             | valid/ready
//   rsp_bus  | out | status, msg_length, addr_type, ipv4_addr,       | valid/ready
//            |     | dest_port, name_char, name_char_valid           |
//
// One request per clock cycle sustained while rsp_bus is ready; each request yields
// exactly one result (input register, then the parse step into the result register).
// Parser state advances only when a request moves from the input register into the
// result register, so a stalled result holds the state and the pipeline behind it.
// Reset is synchronous and active high; it empties both registers and clears the state.
module socks5_request_parser (
   input  logic    clock,
   input  logic    reset,
   s5p_req_if.sink   req_bus,
   s5p_rsp_if.source rsp_bus
);
   import s5p_pkg::*;

   logic       s1_valid_ff;
   item_type   s1_item_ff;
   logic       out_valid_ff;
   result_type out_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   logic       advance;

   // Advance the input register into the result register when the result slot is free
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;

   s5p_step u_step (
      .state      (state_ff),
      .item       (s1_item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // Input register: hold the request until the step can take it
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (req_bus.ready && req_bus.valid) begin
         s1_item_ff.req_type  <= req_bus.req_type;
         s1_item_ff.data_byte <= req_bus.data_byte;
      end
   end

   // Parser state and result register: update together on advance, drop on take
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
         state_ff     <= state_in;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) out_ff <= result_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.status          = out_ff.status;
   assign rsp_bus.msg_length      = out_ff.msg_length;
   assign rsp_bus.addr_type       = out_ff.addr_type;
   assign rsp_bus.ipv4_addr       = out_ff.ipv4_addr;
   assign rsp_bus.dest_port       = out_ff.dest_port;
   assign rsp_bus.name_char       = out_ff.name_char;
   assign rsp_bus.name_char_valid = out_ff.name_char_valid;
endmodule

[rtl/s5p_step.sv]
// s5p_step: combinational per-byte parse step; current state and byte in, next state and result out.
// Depends on s5p_pkg.
module s5p_step (
   input  s5p_pkg::state_type  state,
   input  s5p_pkg::item_type   item,
   output s5p_pkg::state_type  state_next,
   output s5p_pkg::result_type result
);
   import s5p_pkg::*;

   logic [8:0] pos;
   logic [9:0] pos_plus2;
   logic [7:0] b;
   logic [8:0] exp_v;
   logic [8:0] cnt_next;
   logic       check_done;
   logic       is_connect;

   always_comb begin
      pos        = state.byte_count;
      pos_plus2  = {1'b0, pos} + 10'd2;
      b          = item.data_byte;
      is_connect = item.req_type;
      state_next = state;
      result     = '0;
      result.status = ST_PENDING;
      check_done = 1'b0;
      exp_v      = state.expected_length;
      cnt_next   = pos + 9'd1;

      if (pos == POS_VER) begin
         if (b != SOCKS_VERSION) result.status = ST_BAD_VERSION;
      end else if (!is_connect) begin
         if (pos == POS_CMD) exp_v = {1'b0, b} + GREET_EXTRA;
         check_done = 1'b1;
      end else if (pos == POS_CMD) begin
         if (b != CMD_CONNECT) result.status = ST_BAD_COMMAND;
      end else if (pos == POS_RSV) begin
         // reserved byte: not checked
      end else if (pos == POS_ATYP) begin
         state_next.atyp_seen  = b;
         state_next.addr_accum = '0;
         state_next.port_accum = '0;
         if (b == ATYP_IPV4) begin
            exp_v = LEN_IPV4;
         end else if (b == ATYP_IPV6) begin
            result.status = ST_IPV6;
         end else if (b == ATYP_DOMAIN) begin
            exp_v = LEN_DOMAIN0;
         end else begin
            exp_v = LEN_UNKNOWN;
         end
      end else begin
         if (pos == POS_ADDR0 && state.atyp_seen == ATYP_DOMAIN)
            exp_v = {1'b0, b} + DOMAIN_EXTRA;
         if (state.atyp_seen == ATYP_IPV4 && pos >= POS_ADDR0 && pos <= POS_ADDR3)
            state_next.addr_accum = {state.addr_accum[23:0], b};
         // last two bytes of the message carry the port
         if (exp_v >= 9'd2 && pos_plus2 >= {1'b0, exp_v} && pos < exp_v)
            state_next.port_accum = {state.port_accum[7:0], b};
         if (state.atyp_seen == ATYP_DOMAIN && pos >= POS_NAME0 && pos_plus2 < {1'b0, exp_v}) begin
            result.name_char       = b;
            result.name_char_valid = 1'b1;
         end
         check_done = 1'b1;
      end

      state_next.expected_length = exp_v;

      if (result.status == ST_PENDING && check_done && cnt_next >= exp_v) begin
         result.status     = ST_COMPLETE;
         result.msg_length = exp_v;
         if (is_connect) begin
            result.addr_type = state_next.atyp_seen;
            result.ipv4_addr = state_next.addr_accum;
            result.dest_port = state_next.port_accum;
         end
      end

      if (result.status != ST_PENDING) cnt_next = '0;
      state_next.byte_count = cnt_next;
   end
endmodule

[test/testbench.sv]
// testbench: self-checking bench for socks5_request_parser, greeting and connect bytes.
// Depends on s5p_pkg, s5p_req_if, s5p_rsp_if and the parser RTL; needs no other file.
`timescale 1ns / 1ps

module testbench;
   import s5p_pkg::*;

   localparam int RANDOM_ITEMS = 550;   // requests in the random part
   localparam int CALM_TAIL    = 100;   // last requests sent with no idling at all
   localparam int PAUSE_AT     = 250;   // random requests sent before the drain pause
   localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake before giving up
   localparam int DRAIN_CYCLES = 8;     // settle time after the last result

   // Byte-serial parse predictor and store of expected parse results.
   class parse_scoreboard;
      logic [8:0]  position;
      logic [8:0]  msg_len;
      logic [7:0]  atyp;
      logic [31:0] addr;
      logic [15:0] port;
      result_type  expected_q[$];
      int          mismatches;
      int          checked;

      function new();
         position   = '0;
         msg_len    = '0;
         atyp       = '0;
         addr       = '0;
         port       = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      // Advance the parse state by one byte and return the result it produces.
      function result_type parse_byte(logic sel, logic [7:0] b);
         result_type r;
         logic [8:0] p;
         bit         done_check;
         p          = position;
         r          = '0;
         r.status   = ST_PENDING;
         done_check = 0;
         position   = p + 9'd1;

         if (p == POS_VER) begin
            if (b != SOCKS_VERSION) r.status = ST_BAD_VERSION;
         end else if (!sel) begin
            // greeting: the method count fixes the length
            if (p == POS_CMD) msg_len = b + GREET_EXTRA;
            done_check = 1;
         end else if (p == POS_CMD) begin
            if (b != CMD_CONNECT) r.status = ST_BAD_COMMAND;
         end else if (p == POS_RSV) begin
            // reserved byte, never checked
         end else if (p == POS_ATYP) begin
            atyp = b;
            addr = '0;
            port = '0;
            if (b == ATYP_IPV4)        msg_len = LEN_IPV4;
            else if (b == ATYP_IPV6)   r.status = ST_IPV6;
            else if (b == ATYP_DOMAIN) msg_len = LEN_DOMAIN0;
            else                       msg_len = LEN_UNKNOWN;
         end else begin
            if (p == POS_ADDR0 && atyp == ATYP_DOMAIN) msg_len = b + DOMAIN_EXTRA;
            if (atyp == ATYP_IPV4 && p >= POS_ADDR0 && p <= POS_ADDR3)
               addr = {addr[23:0], b};
            // the last two bytes of the message carry the port
            if (msg_len >= 2 && p + 2 >= msg_len && p < msg_len)
               port = {port[7:0], b};
            if (atyp == ATYP_DOMAIN && p >= POS_NAME0 && p + 2 < msg_len) begin
               r.name_char       = b;
               r.name_char_valid = 1'b1;
            end
            done_check = 1;
         end

         if (r.status == ST_PENDING && done_check && position >= msg_len) begin
            r.status     = ST_COMPLETE;
            r.msg_length = msg_len;
            if (sel) begin
               r.addr_type = atyp;
               r.ipv4_addr = addr;
               r.dest_port = port;
            end
         end
         if (r.status != ST_PENDING) position = '0;
         return r;
      endfunction

      function void note_request(logic sel, logic [7:0] b);
         expected_q.push_back(parse_byte(sel, b));
      endfunction

      function bit field_bad(string name, logic [31:0] want, logic [31:0] seen);
         if (want === seen) return 0;
         if (mismatches < 10)
            $display("result %0d %s: expected 0x%0h, got 0x%0h", checked, name, want, seen);
         return 1;
      endfunction

      function void check_result(result_type seen);
         result_type want;
         bit         bad;
         if (expected_q.size() == 0) begin
            if (mismatches < 10) $display("result %0d arrived with nothing expected", checked);
            mismatches++;
            checked++;
            return;
         end
         want = expected_q.pop_front();
         bad  = 0;
         bad |= field_bad("status", 32'(want.status), 32'(seen.status));
         bad |= field_bad("msg_length", 32'(want.msg_length), 32'(seen.msg_length));
         bad |= field_bad("addr_type", 32'(want.addr_type), 32'(seen.addr_type));
         bad |= field_bad("ipv4_addr", want.ipv4_addr, seen.ipv4_addr);
         bad |= field_bad("dest_port", 32'(want.dest_port), 32'(seen.dest_port));
         bad |= field_bad("name_char", 32'(want.name_char), 32'(seen.name_char));
         bad |= field_bad("name_char_valid", 32'(want.name_char_valid),
                          32'(seen.name_char_valid));
         if (bad) mismatches++;
         checked++;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;      // when set, neither side idles
   int   sent_count = 0;
   int   stall_left = 0;
   int   idle_cycles = 0;

   parse_scoreboard sb = new();

   s5p_req_if req_bus ();
   s5p_rsp_if rsp_bus ();

   socks5_request_parser DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: hold ready low in random bursts now and then.
   always @(posedge clock) begin
      if (calm) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left    <= $urandom_range(0, 10);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Observe both handshakes: predict on each accepted request, check each result,
   // and drop the run if nothing moves for too long.
   always @(posedge clock) begin
      result_type seen;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.req_type, req_bus.data_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.status          = rsp_bus.status;
            seen.msg_length      = rsp_bus.msg_length;
            seen.addr_type       = rsp_bus.addr_type;
            seen.ipv4_addr       = rsp_bus.ipv4_addr;
            seen.dest_port       = rsp_bus.dest_port;
            seen.name_char       = rsp_bus.name_char;
            seen.name_char_valid = rsp_bus.name_char_valid;
            sb.check_result(seen);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Offer one request and hold it until the parser takes it; idle first now and then.
   task automatic send_request(input logic sel, input logic [7:0] b);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 11);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= sel;
      req_bus.data_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
   endtask

   // Method-selection greeting: version, count, then that many method bytes.
   task automatic send_greeting(input int n_methods);
      send_request(1'b0, SOCKS_VERSION);
      send_request(1'b0, 8'(n_methods));
      repeat (n_methods) send_request(1'b0, 8'($urandom));
   endtask

   // Connect request with random reserved byte, address and port.
   task automatic send_connect(input logic [7:0] atyp, input int name_len);
      send_request(1'b1, SOCKS_VERSION);
      send_request(1'b1, CMD_CONNECT);
      send_request(1'b1, 8'($urandom));
      send_request(1'b1, atyp);
      if (atyp == ATYP_IPV6) return;          // refused at the type byte
      if (atyp == ATYP_IPV4) begin
         repeat (4) send_request(1'b1, 8'($urandom));
      end else if (atyp == ATYP_DOMAIN) begin
         send_request(1'b1, 8'(name_len));
         repeat (name_len) send_request(1'b1, 8'($urandom));
      end
      repeat (2) send_request(1'b1, 8'($urandom));
   endtask

   initial begin
      int         kind;
      int         msg_no;
      int         start;
      int         n;
      logic [7:0] b;
      bit         paused;

      req_bus.valid     = 1'b0;
      req_bus.req_type  = 1'b0;
      req_bus.data_byte = 8'h00;
      rsp_bus.ready     = 1'b0;
      paused            = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: version and command errors, the shortest greeting,
      // IPv6 refusal, IPv4 with extreme octets and an empty domain name.
      send_request(1'b0, 8'hFF);
      send_request(1'b0, SOCKS_VERSION);
      send_request(1'b0, 8'h00);
      send_request(1'b1, SOCKS_VERSION);
      send_request(1'b1, 8'h02);
      send_request(1'b1, SOCKS_VERSION);
      send_request(1'b1, CMD_CONNECT);
      send_request(1'b1, 8'hFF);
      send_request(1'b1, ATYP_IPV6);
      send_request(1'b1, SOCKS_VERSION);
      send_request(1'b1, CMD_CONNECT);
      send_request(1'b1, 8'h00);
      send_request(1'b1, ATYP_IPV4);
      send_request(1'b1, 8'h00);
      send_request(1'b1, 8'h80);
      send_request(1'b1, 8'h7F);
      send_request(1'b1, 8'hFF);
      send_request(1'b1, 8'hFF);
      send_request(1'b1, 8'hFF);
      send_request(1'b1, SOCKS_VERSION);
      send_request(1'b1, CMD_CONNECT);
      send_request(1'b1, 8'h00);
      send_request(1'b1, ATYP_DOMAIN);
      send_request(1'b1, 8'h00);
      send_request(1'b1, 8'h12);
      send_request(1'b1, 8'h34);

      // Random part: mostly well-formed messages with random content, the rest
      // errors, noise and messages cut short or switched between selectors.
      start  = sent_count;
      msg_no = 0;
      while (sent_count - start < RANDOM_ITEMS) begin
         calm <= (sent_count - start >= RANDOM_ITEMS - CALM_TAIL) ||
                 ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 19);
         // force one greeting and one domain name of the largest size
         if (msg_no == 10) kind = 0;
         if (msg_no == 30) kind = 8;

         if (kind <= 3) begin
            n = (msg_no == 10) ? 255 : $urandom_range(0, 6);
            send_greeting(n);
         end else if (kind <= 7) begin
            send_connect(ATYP_IPV4, 0);
         end else if (kind <= 10) begin
            n = (msg_no == 30) ? 255 : $urandom_range(0, 12);
            send_connect(ATYP_DOMAIN, n);
         end else if (kind == 11) begin
            b = 8'($urandom);
            if (b == ATYP_IPV4 || b == ATYP_DOMAIN || b == ATYP_IPV6) b = b ^ 8'h80;
            send_connect(b, 0);
         end else if (kind == 12) begin
            send_connect(ATYP_IPV6, 0);
         end else if (kind == 13) begin
            b = 8'($urandom);
            if (b == SOCKS_VERSION) b = b ^ 8'h80;
            send_request(1'($urandom), b);
         end else if (kind == 14) begin
            b = 8'($urandom);
            if (b == CMD_CONNECT) b = b ^ 8'h80;
            send_request(1'b1, SOCKS_VERSION);
            send_request(1'b1, b);
         end else if (kind <= 16) begin
            repeat ($urandom_range(1, 6)) send_request(1'($urandom), 8'($urandom));
         end else begin
            // start a connect, then carry on with greeting bytes
            send_request(1'b1, SOCKS_VERSION);
            send_request(1'b1, CMD_CONNECT);
            send_request(1'b1, 8'($urandom));
            send_request(1'b1, ATYP_IPV4);
            repeat ($urandom_range(0, 4)) send_request(1'b0, 8'($urandom));
         end
         msg_no++;

         // Hold off once until every expected result has come back.
         if (!paused && sent_count - start >= PAUSE_AT) begin
            paused = 1;
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (sb.outstanding() != 0);
         end
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
